/* rtl/core/gate_motor_sequencer_assert.svh */
// Assertion macros for the gate motor sequencer
`ifndef GATE_MOTOR_SEQUENCER_ASSERT_SVH
`define GATE_MOTOR_SEQUENCER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define GMS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gms check failed");
// Next-cycle implication checked outside reset
`define GMS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gms check failed");
`endif

/* rtl/core/gms_pkg.sv */
// Shared types and constants of the gate motor sequencer
package gms_pkg;
   localparam logic [1:0] MODE_STOP  = 2'd0;
   localparam logic [1:0] MODE_OPEN  = 2'd1;
   localparam logic [1:0] MODE_CLOSE = 2'd2;
   localparam logic [1:0] MODE_ERR   = 2'd3;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_OPENED  = 3'd1;
   localparam logic [2:0] EV_CLOSED  = 3'd2;
   localparam logic [2:0] EV_STALL   = 3'd3;
   localparam logic [2:0] EV_PARTIAL = 3'd4;
   localparam logic [2:0] EV_ERRRST  = 3'd5;

   localparam logic [1:0] BLINK_IDLE  = 2'd0;
   localparam logic [1:0] BLINK_PAUSE = 2'd1;
   localparam logic [1:0] BLINK_LIT   = 2'd2;

   localparam logic [2:0] CSR_RELAY   = 3'd0;
   localparam logic [2:0] CSR_REVERSE = 3'd1;
   localparam logic [2:0] CSR_STALL   = 3'd2;
   localparam logic [2:0] CSR_DOUBLE  = 3'd3;
   localparam logic [2:0] CSR_DEBOUNCE= 3'd4;
   localparam logic [2:0] CSR_RAMP    = 3'd5;
   localparam logic [2:0] CSR_FSTART  = 3'd6;
   localparam logic [2:0] CSR_FCRUISE = 3'd7;

   localparam int DELAY_W = 14;

   // one sampled tick, as queued between front and back
   typedef struct packed {
      logic       command_button;
      logic       reset_button;
      logic       open_limit_hit;
      logic       closed_limit_hit;
      logic       main_encoder_pulse;
      logic [3:0] hall_pulses;
   } tick_type;

   // one result item
   typedef struct packed {
      logic [1:0]          door_state;
      logic                relay_open_on;
      logic                relay_close_on;
      logic                power_enable;
      logic [DELAY_W-1:0]  fire_delay_us;
      logic                led_on;
      logic [2:0]          event_res;
      logic                trip_complete;
      logic signed [31:0]  trip_count;
   } result_type;

   // divider handshake
   typedef struct packed {
      logic                start;
      logic [29:0]         dividend;
      logic [15:0]         divisor;
   } div_req_type;
endpackage

/* rtl/core/gms_queue.sv */
// Two-entry tick queue between front end and sequencer
module gms_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  gms_pkg::tick_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output gms_pkg::tick_type rd_data
);
   import gms_pkg::*;

   tick_type   mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_wr, do_rd;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   // pointer and fill update
   always_comb begin
      wptr_in = wptr_ff ^ do_wr;
      rptr_in = rptr_ff ^ do_rd;
      cnt_in  = cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end
endmodule

/* rtl/core/gms_divider.sv */
// Restoring divider, one quotient bit per cycle
module gms_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  gms_pkg::div_req_type req,
   output logic                 busy,
   output logic [29:0]          quotient
);
   import gms_pkg::*;

   localparam int NB = 30;

   logic [NB-1:0] q_ff, q_in;
   logic [16:0]   r_ff, r_in;
   logic [15:0]   d_ff, d_in;
   logic [4:0]    n_ff, n_in;
   logic          busy_ff, busy_in;
   logic [16:0]   trial;
   logic [17:0]   diff;

   assign busy     = busy_ff;
   assign quotient = q_ff;

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      n_in    = n_ff;
      busy_in = busy_ff;
      trial   = {r_ff[15:0], q_ff[NB-1]};
      diff    = {1'b0, trial} - {2'b00, d_ff};
      if (req.start) begin
         q_in    = req.dividend;
         r_in    = 17'd0;
         d_in    = req.divisor;
         n_in    = 5'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[17]) begin
            r_in = diff[16:0];
            q_in = {q_ff[NB-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NB-2:0], 1'b0};
         end
         n_in = n_ff - 5'd1;
         if (n_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff    <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         n_ff    <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end
endmodule

/* rtl/core/gms_sequencer.sv */
// Back end: per-tick gate sequencing, ramp and result register
module gms_sequencer #(
   parameter int LED_PAUSE_MS = 200,
   parameter int LED_BLINK_MS = 200,
   parameter int TIME_BITS    = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                tick_valid,
   output logic                tick_ready,
   input  gms_pkg::tick_type   tick,
   input  logic [15:0]         settle_wait_ms,
   input  logic [15:0]         reversal_wait_ms,
   input  logic [15:0]         stall_timeout_ms,
   input  logic [15:0]         double_press_ms,
   input  logic [15:0]         debounce_ms,
   input  logic [15:0]         ramp_ms,
   input  logic [13:0]         fire_delay_start_us,
   input  logic [13:0]         fire_delay_cruise_us,
   output logic                res_valid,
   input  logic                res_ready,
   output gms_pkg::result_type res
);
   import gms_pkg::*;

   localparam int TW = TIME_BITS;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_WAIT = 4'b0100,
      S_OUT  = 4'b1000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   logic [TW-1:0] now_ff, now_in;
   logic [1:0]    mode_ff, mode_in, pend_ff, pend_in, arr_ff, arr_in, tdir_ff, tdir_in;
   logic          armed_ff, armed_in, cprev_ff, cprev_in, rprev_ff, rprev_in;
   logic          tvalid_ff, tvalid_in;
   logic [TW-1:0] cacc_ff, cacc_in, racc_ff, racc_in, mpress_ff, mpress_in;
   logic [TW-1:0] dirt_ff, dirt_in, stopt_ff, stopt_in, enc_ff, enc_in;
   logic [TW-1:0] rampt_ff, rampt_in, blinkt_ff, blinkt_in;
   logic [13:0]   fdel_ff, fdel_in;
   logic [1:0]    blink_ff, blink_in;
   logic [31:0]   tcnt_ff, tcnt_in;
   result_type    res_ff, res_in;

   // ramp pending: base value, direction, from the tick step
   logic          rpend_ff, rpend_in, rdown_ff, rdown_in;
   logic [13:0]   rbase_ff, rbase_in;

   div_req_type   dreq;
   logic          dbusy;
   logic [29:0]   dquot;
   logic [15:0]   elapsed16_ff, elapsed16_in;
   logic [13:0]   span_ff, span_in;

   gms_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (dreq),
      .busy     (dbusy),
      .quotient (dquot)
   );

   assign tick_ready = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_OUT);
   assign res        = res_ff;

   function automatic logic [TW-1:0] since(input logic [TW-1:0] n, input logic [TW-1:0] t);
      return n - t;
   endfunction

   // one tick of the sequencer, computed combinationally from the stored state
   always_comb begin
      logic       rise_c, rise_r, acc_c, acc_r, at_open, at_close, at_dest, dbl;
      logic [1:0] dir, opp;
      logic [2:0] ev;
      logic       tdone;
      logic [31:0] tout;
      logic       do_press;
      mode_in = mode_ff; pend_in = pend_ff; arr_in = arr_ff; tdir_in = tdir_ff;
      armed_in = armed_ff; cprev_in = cprev_ff; rprev_in = rprev_ff;
      tvalid_in = tvalid_ff; cacc_in = cacc_ff; racc_in = racc_ff;
      mpress_in = mpress_ff; dirt_in = dirt_ff; stopt_in = stopt_ff;
      enc_in = enc_ff; rampt_in = rampt_ff; blinkt_in = blinkt_ff;
      fdel_in = fdel_ff; blink_in = blink_ff; tcnt_in = tcnt_ff;
      rpend_in = 1'b0; rdown_in = 1'b0; rbase_in = fdel_ff;
      elapsed16_in = elapsed16_ff; span_in = span_ff;
      ev = EV_NONE; tdone = 1'b0; tout = 32'd0; do_press = 1'b0;
      dir = MODE_STOP; opp = MODE_STOP; dbl = 1'b0;
      at_open = tick.open_limit_hit; at_close = tick.closed_limit_hit; at_dest = 1'b0;

      if (tick.main_encoder_pulse || tick.hall_pulses != 4'd0) enc_in = now_ff;
      if (tvalid_ff) begin
         if (mode_ff == tdir_ff) tcnt_in = tcnt_ff + {28'd0, tick.hall_pulses};
         else tcnt_in = tcnt_ff - {28'd0, tick.hall_pulses};
      end

      // reset button edge
      rise_r   = tick.reset_button && !rprev_ff;
      rprev_in = tick.reset_button;
      acc_r    = rise_r && (since(now_ff, racc_ff) >= TW'(debounce_ms));
      if (acc_r) racc_in = now_ff;

      // blink
      if (blink_ff == BLINK_PAUSE) begin
         if (since(now_ff, blinkt_ff) >= TW'(LED_PAUSE_MS)) begin
            blinkt_in = now_ff;
            blink_in  = BLINK_LIT;
         end
      end else if (blink_ff == BLINK_LIT) begin
         if (since(now_ff, blinkt_ff) >= TW'(LED_BLINK_MS)) blink_in = BLINK_IDLE;
      end

      rise_c = tick.command_button && !cprev_ff;
      acc_c  = rise_c && (since(now_ff, cacc_ff) >= TW'(debounce_ms));

      unique case (mode_ff)
         MODE_STOP: begin
            cprev_in = tick.command_button;
            if (acc_c) cacc_in = now_ff;
            if (pend_ff != MODE_STOP) begin
               if (acc_c) begin
                  do_press = 1'b1;
                  opp = pend_ff;
               end else if (since(now_ff, stopt_ff) >= TW'(reversal_wait_ms)) begin
                  pend_in = MODE_STOP;
                  dirt_in = now_ff; armed_in = 1'b0; mode_in = pend_ff; blink_in = BLINK_IDLE;
               end
            end else if (acc_c) begin
               if (at_open) dir = MODE_CLOSE;
               else if (at_close) dir = MODE_OPEN;
               else if (arr_ff == MODE_CLOSE) dir = MODE_OPEN;
               else dir = MODE_CLOSE;
               if (at_open || at_close) begin
                  tcnt_in = 32'd0; tdir_in = dir; tvalid_in = 1'b1;
               end else begin
                  tvalid_in = 1'b0;
               end
               dirt_in = now_ff; armed_in = 1'b0; mode_in = dir; blink_in = BLINK_IDLE;
            end
         end
         MODE_OPEN, MODE_CLOSE: begin
            logic armed_v;
            logic [TW-1:0] encv, rampv, el;
            armed_v = armed_ff; encv = enc_in; rampv = rampt_ff; el = '0;
            at_dest = (mode_ff == MODE_OPEN) ? at_open : at_close;
            if (!armed_ff && since(now_ff, dirt_ff) >= TW'(settle_wait_ms)) begin
               rampv = now_ff; armed_v = 1'b1; encv = now_ff;
            end
            rampt_in = rampv; enc_in = encv; armed_in = armed_v;
            if (armed_v) begin
               el = since(now_ff, rampv);
               if (el >= TW'(ramp_ms)) begin
                  fdel_in = fire_delay_cruise_us;
               end else begin
                  rpend_in = 1'b1;
                  elapsed16_in = el[15:0];
                  if (fire_delay_start_us >= fire_delay_cruise_us) begin
                     rdown_in = 1'b1;
                     span_in  = fire_delay_start_us - fire_delay_cruise_us;
                  end else begin
                     span_in  = fire_delay_cruise_us - fire_delay_start_us;
                  end
                  rbase_in = fire_delay_start_us;
               end
            end
            if (at_dest) begin
               armed_in = 1'b0; mode_in = MODE_STOP; stopt_in = now_ff;
               arr_in = mode_ff;
               if (tvalid_ff) begin
                  tdone = 1'b1; tout = tcnt_in;
               end
               tvalid_in = 1'b0;
               blink_in = BLINK_PAUSE; blinkt_in = now_ff;
               ev = (mode_ff == MODE_OPEN) ? EV_OPENED : EV_CLOSED;
            end else if (armed_v && since(now_ff, encv) > TW'(stall_timeout_ms)) begin
               armed_in = 1'b0; mode_in = MODE_ERR; tvalid_in = 1'b0; ev = EV_STALL;
            end else begin
               cprev_in = tick.command_button;
               if (acc_c) begin
                  cacc_in = now_ff;
                  do_press = 1'b1;
                  opp = (mode_ff == MODE_OPEN) ? MODE_CLOSE : MODE_OPEN;
               end
            end
         end
         default: begin
            if (acc_r) begin
               pend_in = MODE_STOP; mode_in = MODE_STOP; stopt_in = now_ff; ev = EV_ERRRST;
            end
         end
      endcase

      // press on a moving gate, or during a reversal wait
      if (do_press) begin
         dbl = since(now_ff, mpress_ff) < TW'(double_press_ms);
         mpress_in = now_ff;
         armed_in = 1'b0; mode_in = MODE_STOP; stopt_in = now_ff;
         if (dbl) begin
            pend_in = MODE_STOP; tvalid_in = 1'b0; ev = EV_PARTIAL;
         end else begin
            pend_in = opp;
         end
      end

      res_in.door_state     = mode_in;
      res_in.relay_open_on  = (mode_in == MODE_OPEN);
      res_in.relay_close_on = (mode_in == MODE_CLOSE);
      res_in.power_enable   = armed_in;
      res_in.fire_delay_us  = fdel_in;
      res_in.led_on         = (mode_in == MODE_OPEN) || (mode_in == MODE_CLOSE) ||
                              (blink_in == BLINK_LIT);
      res_in.event_res      = ev;
      res_in.trip_complete  = tdone;
      res_in.trip_count     = tout;
      now_in = now_ff + TW'(1);
   end

   // divider launch and ramp result
   assign dreq.start    = (state_ff == S_DIV);
   assign dreq.dividend = 30'(span_ff) * 30'(elapsed16_ff);
   assign dreq.divisor  = ramp_ms;

   // control sequence: take tick, divide if ramping, present result
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (tick_valid) state_in = rpend_in ? S_DIV : S_OUT;
         S_DIV:  state_in = S_WAIT;
         S_WAIT: if (!dbusy) state_in = S_OUT;
         S_OUT:  if (res_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         now_ff <= '0; mode_ff <= MODE_STOP; pend_ff <= MODE_STOP; arr_ff <= MODE_STOP;
         tdir_ff <= MODE_STOP; armed_ff <= 1'b0; cprev_ff <= 1'b0; rprev_ff <= 1'b0;
         tvalid_ff <= 1'b0; cacc_ff <= '0; racc_ff <= '0; mpress_ff <= '0; dirt_ff <= '0;
         stopt_ff <= '0; enc_ff <= '0; rampt_ff <= '0; blinkt_ff <= '0;
         fdel_ff <= 14'd8000; blink_ff <= BLINK_IDLE; tcnt_ff <= 32'd0;
         rdown_ff <= 1'b0; rbase_ff <= 14'd0; elapsed16_ff <= 16'd0; span_ff <= 14'd0;
         rpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && tick_valid) begin
            now_ff <= now_in; mode_ff <= mode_in; pend_ff <= pend_in; arr_ff <= arr_in;
            tdir_ff <= tdir_in; armed_ff <= armed_in; cprev_ff <= cprev_in;
            rprev_ff <= rprev_in; tvalid_ff <= tvalid_in; cacc_ff <= cacc_in;
            racc_ff <= racc_in; mpress_ff <= mpress_in; dirt_ff <= dirt_in;
            stopt_ff <= stopt_in; enc_ff <= enc_in; rampt_ff <= rampt_in;
            blinkt_ff <= blinkt_in; fdel_ff <= fdel_in; blink_ff <= blink_in;
            tcnt_ff <= tcnt_in; rdown_ff <= rdown_in; rbase_ff <= rbase_in;
            elapsed16_ff <= elapsed16_in; span_ff <= span_in; rpend_ff <= rpend_in;
            res_ff <= res_in;
         end else if (state_ff == S_WAIT && !dbusy) begin
            // quotient < span, fits in 14 bits
            if (rdown_ff) fdel_ff <= rbase_ff - dquot[13:0];
            else fdel_ff <= rbase_ff + dquot[13:0];
            res_ff.fire_delay_us <= rdown_ff ? (rbase_ff - dquot[13:0])
                                             : (rbase_ff + dquot[13:0]);
         end
      end
   end
endmodule

/* rtl/core/gms_front.sv */
// Front end: tick intake and configuration registers
module gms_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              in_cmd,
   input  logic              in_rst,
   input  logic              in_open,
   input  logic              in_closed,
   input  logic              in_enc,
   input  logic [3:0]        in_hall,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data,
   output logic              q_valid,
   input  logic              q_ready,
   output gms_pkg::tick_type q_data,
   output logic [15:0]       settle_wait_ms,
   output logic [15:0]       reversal_wait_ms,
   output logic [15:0]       stall_timeout_ms,
   output logic [15:0]       double_press_ms,
   output logic [15:0]       debounce_ms,
   output logic [15:0]       ramp_ms,
   output logic [13:0]       fire_delay_start_us,
   output logic [13:0]       fire_delay_cruise_us
);
   import gms_pkg::*;

   logic [15:0] r_ff [6];
   logic [13:0] fs_ff, fc_ff;
   tick_type    w;

   assign w = '{command_button: in_cmd, reset_button: in_rst, open_limit_hit: in_open,
                closed_limit_hit: in_closed, main_encoder_pulse: in_enc,
                hall_pulses: in_hall};

   gms_queue u_q (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_data  (w),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   assign csr_ready = 1'b1;
   assign settle_wait_ms       = r_ff[0];
   assign reversal_wait_ms     = r_ff[1];
   assign stall_timeout_ms     = r_ff[2];
   assign double_press_ms      = r_ff[3];
   assign debounce_ms          = r_ff[4];
   assign ramp_ms              = r_ff[5];
   assign fire_delay_start_us  = fs_ff;
   assign fire_delay_cruise_us = fc_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff[0] <= 16'd100; r_ff[1] <= 16'd1000; r_ff[2] <= 16'd1000;
         r_ff[3] <= 16'd500; r_ff[4] <= 16'd50;   r_ff[5] <= 16'd2000;
         fs_ff <= 14'd8000; fc_ff <= 14'd1000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RELAY:    r_ff[0] <= csr_data;
            CSR_REVERSE:  r_ff[1] <= csr_data;
            CSR_STALL:    r_ff[2] <= csr_data;
            CSR_DOUBLE:   r_ff[3] <= csr_data;
            CSR_DEBOUNCE: r_ff[4] <= csr_data;
            CSR_RAMP:     r_ff[5] <= csr_data;
            CSR_FSTART:   fs_ff <= csr_data[13:0];
            CSR_FCRUISE:  fc_ff <= csr_data[13:0];
            default: ;
         endcase
      end
   end
endmodule

/* rtl/core/gate_motor_sequencer.sv */
// Gate motor sequencer top level: one result per millisecond tick. A tick
// passes a two-entry queue; the sequencer takes one tick at a time and holds
// it until its result has been taken. Without a ramp, the result is presented
// in the cycle after the sequencer takes the tick. While the firing delay
// ramps, span times elapsed time is divided by the ramp length in a 30-bit
// bit-serial divider (launch, then the 30 quotient bits, then finish) before
// the result is presented. A receiver that holds off keeps the sequencer waiting;
// the queue then fills and the input stalls.
module gate_motor_sequencer #(
   parameter int LED_PAUSE_MS = 200,
   parameter int LED_BLINK_MS = 200,
   parameter int TIME_BITS    = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command_button,
   input  logic               req_reset_button,
   input  logic               req_open_limit_hit,
   input  logic               req_closed_limit_hit,
   input  logic               req_main_encoder_pulse,
   input  logic [3:0]         req_hall_pulses,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_door_state,
   output logic               rsp_relay_open_on,
   output logic               rsp_relay_close_on,
   output logic               rsp_power_enable,
   output logic [13:0]        rsp_fire_delay_us,
   output logic               rsp_led_on,
   output logic [2:0]         rsp_event_res,
   output logic               rsp_trip_complete,
   output logic signed [31:0] rsp_trip_count
);
   import gms_pkg::*;
`include "gate_motor_sequencer_assert.svh"

   logic        q_valid, q_ready;
   tick_type    q_data;
   result_type  r;
   logic [15:0] c0, c1, c2, c3, c4, c5;
   logic [13:0] c6, c7;

   gms_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .in_cmd(req_command_button), .in_rst(req_reset_button),
      .in_open(req_open_limit_hit), .in_closed(req_closed_limit_hit),
      .in_enc(req_main_encoder_pulse), .in_hall(req_hall_pulses),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .settle_wait_ms(c0), .reversal_wait_ms(c1), .stall_timeout_ms(c2),
      .double_press_ms(c3), .debounce_ms(c4), .ramp_ms(c5),
      .fire_delay_start_us(c6), .fire_delay_cruise_us(c7)
   );

   gms_sequencer #(
      .LED_PAUSE_MS(LED_PAUSE_MS), .LED_BLINK_MS(LED_BLINK_MS), .TIME_BITS(TIME_BITS)
   ) u_seq (
      .clock(clock), .reset(reset), .tick_valid(q_valid), .tick_ready(q_ready),
      .tick(q_data), .settle_wait_ms(c0), .reversal_wait_ms(c1),
      .stall_timeout_ms(c2), .double_press_ms(c3), .debounce_ms(c4), .ramp_ms(c5),
      .fire_delay_start_us(c6), .fire_delay_cruise_us(c7),
      .res_valid(rsp_valid), .res_ready(rsp_ready), .res(r)
   );

   assign rsp_door_state     = r.door_state;
   assign rsp_relay_open_on  = r.relay_open_on;
   assign rsp_relay_close_on = r.relay_close_on;
   assign rsp_power_enable   = r.power_enable;
   assign rsp_fire_delay_us  = r.fire_delay_us;
   assign rsp_led_on         = r.led_on;
   assign rsp_event_res      = r.event_res;
   assign rsp_trip_complete  = r.trip_complete;
   assign rsp_trip_count     = r.trip_count;

   `GMS_ASSERT_IMP(a_relays_excl, rsp_valid, !(rsp_relay_open_on && rsp_relay_close_on))
   `GMS_ASSERT_IMP(a_trip_zero, rsp_valid && !rsp_trip_complete, rsp_trip_count == 32'sd0)
   `GMS_ASSERT_IMP(a_power_moving, rsp_valid && rsp_power_enable,
                   rsp_relay_open_on || rsp_relay_close_on)
   `GMS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the gate motor sequencer: scoreboard, drivers and monitors
`timescale 1ns / 1ps

import gms_pkg::*;

// Scoreboard: per-tick behavioral prediction of the sequencer and an in-order result check
class gate_scoreboard;
   bit [15:0] settle_ms, rev_stop_ms, stall_ms, dbl_ms, debounce_ms, ramp_len;
   bit [13:0] start_us, cruise_us;
   bit [31:0] now, cmd_stamp, rst_stamp, press_stamp, dir_stamp, stop_stamp;
   bit [31:0] enc_stamp, ramp_stamp, blink_stamp, trip_cnt, trip_out;
   logic [1:0] mode, pend_dir, last_arrival, trip_dir, blink;
   bit armed, cmd_prev, rst_prev, trip_ok, trip_done;
   bit [13:0] fdelay;
   logic [2:0] ev;
   result_type expected_q[$];
   int errors;

   function new();
      settle_ms = 100; rev_stop_ms = 1000; stall_ms = 1000; dbl_ms = 500;
      debounce_ms = 50; ramp_len = 2000; start_us = 8000; cruise_us = 1000;
      now = 0; cmd_stamp = 0; rst_stamp = 0; press_stamp = 0; dir_stamp = 0;
      stop_stamp = 0; enc_stamp = 0; ramp_stamp = 0; blink_stamp = 0; trip_cnt = 0;
      mode = MODE_STOP; pend_dir = MODE_STOP; last_arrival = MODE_STOP;
      trip_dir = MODE_STOP; blink = BLINK_IDLE;
      armed = 0; cmd_prev = 0; rst_prev = 0; trip_ok = 0;
      fdelay = start_us;
      errors = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
         CSR_RELAY:    settle_ms = data;
         CSR_REVERSE:  rev_stop_ms = data;
         CSR_STALL:    stall_ms = data;
         CSR_DOUBLE:   dbl_ms = data;
         CSR_DEBOUNCE: debounce_ms = data;
         CSR_RAMP:     ramp_len = data;
         CSR_FSTART:   start_us = data[13:0];
         CSR_FCRUISE:  cruise_us = data[13:0];
         default: ;
      endcase
   endfunction

   function bit [31:0] age(bit [31:0] stamp);
      return now - stamp;
   endfunction

   // debounced rising edges, one per button
   function bit cmd_edge(bit level);
      bit rise;
      rise = level && !cmd_prev;
      cmd_prev = level;
      if (!rise || age(cmd_stamp) < debounce_ms) return 0;
      cmd_stamp = now;
      return 1;
   endfunction

   function bit rst_edge(bit level);
      bit rise;
      rise = level && !rst_prev;
      rst_prev = level;
      if (!rise || age(rst_stamp) < debounce_ms) return 0;
      rst_stamp = now;
      return 1;
   endfunction

   function void ramp_step();
      longint e, s, c;
      e = age(ramp_stamp);
      s = start_us;
      c = cruise_us;
      if (e >= ramp_len) fdelay = 14'(c);
      else if (s >= c) fdelay = 14'(s - ((s - c) * e) / ramp_len);
      else fdelay = 14'(s + ((c - s) * e) / ramp_len);
   endfunction

   function void start_move(logic [1:0] d);
      dir_stamp = now;
      armed = 0;
      mode = d;
      blink = BLINK_IDLE;
   endfunction

   function void halt();
      armed = 0;
      mode = MODE_STOP;
      stop_stamp = now;
   endfunction

   // press on a moving gate (or during a reversal wait)
   function void moving_press(logic [1:0] opposite);
      bit dbl;
      dbl = age(press_stamp) < dbl_ms;
      press_stamp = now;
      halt();
      if (dbl) begin
         pend_dir = MODE_STOP;
         trip_ok = 0;
         ev = EV_PARTIAL;
      end else begin
         pend_dir = opposite;
      end
   endfunction

   function void stopped_tick(tick_type t);
      logic [1:0] d;
      if (pend_dir != MODE_STOP) begin
         if (cmd_edge(t.command_button)) begin
            moving_press(pend_dir);
            return;
         end
         if (age(stop_stamp) >= rev_stop_ms) begin
            d = pend_dir;
            pend_dir = MODE_STOP;
            start_move(d);
         end
         return;
      end
      if (!cmd_edge(t.command_button)) return;
      if (t.open_limit_hit) d = MODE_CLOSE;
      else if (t.closed_limit_hit) d = MODE_OPEN;
      else if (last_arrival == MODE_CLOSE) d = MODE_OPEN;
      else d = MODE_CLOSE;
      if (t.open_limit_hit || t.closed_limit_hit) begin
         trip_cnt = 0;
         trip_dir = d;
         trip_ok = 1;
      end else begin
         trip_ok = 0;
      end
      start_move(d);
   endfunction

   function void moving_tick(tick_type t, logic [1:0] d);
      bit at_dest;
      at_dest = (d == MODE_OPEN) ? t.open_limit_hit : t.closed_limit_hit;
      if (!armed && age(dir_stamp) >= settle_ms) begin
         ramp_stamp = now;
         fdelay = start_us;
         armed = 1;
         enc_stamp = now;
      end
      if (armed) ramp_step();
      if (at_dest) begin
         halt();
         last_arrival = d;
         if (trip_ok) begin
            trip_done = 1;
            trip_out = trip_cnt;
         end
         trip_ok = 0;
         blink = BLINK_PAUSE;
         blink_stamp = now;
         ev = (d == MODE_OPEN) ? EV_OPENED : EV_CLOSED;
         return;
      end
      if (armed && age(enc_stamp) > stall_ms) begin
         armed = 0;
         mode = MODE_ERR;
         trip_ok = 0;
         ev = EV_STALL;
         return;
      end
      if (cmd_edge(t.command_button))
         moving_press(d == MODE_OPEN ? MODE_CLOSE : MODE_OPEN);
   endfunction

   // one accepted tick: advance the prediction and queue the expected result
   function void note_tick(tick_type t);
      bit rst_hit;
      result_type r;
      ev = EV_NONE;
      trip_done = 0;
      trip_out = 0;
      if (t.main_encoder_pulse || t.hall_pulses != 0) enc_stamp = now;
      if (trip_ok) begin
         if (mode == trip_dir) trip_cnt = trip_cnt + {28'd0, t.hall_pulses};
         else trip_cnt = trip_cnt - {28'd0, t.hall_pulses};
      end
      rst_hit = rst_edge(t.reset_button);
      if (blink == BLINK_PAUSE) begin
         if (age(blink_stamp) >= 200) begin
            blink_stamp = now;
            blink = BLINK_LIT;
         end
      end else if (blink == BLINK_LIT) begin
         if (age(blink_stamp) >= 200) blink = BLINK_IDLE;
      end
      case (mode)
         MODE_STOP:  stopped_tick(t);
         MODE_OPEN:  moving_tick(t, MODE_OPEN);
         MODE_CLOSE: moving_tick(t, MODE_CLOSE);
         default: begin
            if (rst_hit) begin
               pend_dir = MODE_STOP;
               mode = MODE_STOP;
               stop_stamp = now;
               ev = EV_ERRRST;
            end
         end
      endcase
      r.door_state = mode;
      r.relay_open_on = (mode == MODE_OPEN);
      r.relay_close_on = (mode == MODE_CLOSE);
      r.power_enable = armed;
      r.fire_delay_us = fdelay;
      r.led_on = (mode == MODE_OPEN || mode == MODE_CLOSE || blink == BLINK_LIT);
      r.event_res = ev;
      r.trip_complete = trip_done;
      r.trip_count = trip_out;
      expected_q.push_back(r);
      now = now + 1;
   endfunction

   function void field_cmp(string name, longint e, longint a);
      if (e != a) begin
         $display("%0t: mismatch %s expected %0d actual %0d", $time, name, e, a);
         errors++;
      end
   endfunction

   function void check(result_type a);
      result_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result, door_state %0d", $time, a.door_state);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      field_cmp("door_state", e.door_state, a.door_state);
      field_cmp("relay_open_on", e.relay_open_on, a.relay_open_on);
      field_cmp("relay_close_on", e.relay_close_on, a.relay_close_on);
      field_cmp("power_enable", e.power_enable, a.power_enable);
      field_cmp("fire_delay_us", e.fire_delay_us, a.fire_delay_us);
      field_cmp("led_on", e.led_on, a.led_on);
      field_cmp("event_res", e.event_res, a.event_res);
      field_cmp("trip_complete", e.trip_complete, a.trip_complete);
      field_cmp("trip_count", e.trip_count, a.trip_count);
   endfunction
endclass

module tb_top;
   localparam int IDLE_LIMIT = 20000;

   logic clock, reset;
   logic req_valid, req_ready;
   logic req_command_button, req_reset_button, req_open_limit_hit;
   logic req_closed_limit_hit, req_main_encoder_pulse;
   logic [3:0] req_hall_pulses;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [15:0] csr_data;
   logic rsp_valid, rsp_ready;
   logic [1:0] rsp_door_state;
   logic rsp_relay_open_on, rsp_relay_close_on, rsp_power_enable, rsp_led_on;
   logic [13:0] rsp_fire_delay_us;
   logic [2:0] rsp_event_res;
   logic rsp_trip_complete;
   logic signed [31:0] rsp_trip_count;

   gate_scoreboard sb;
   bit hold_req;
   int idle_cycles;

   gate_motor_sequencer DUT (.*);

   // clock
   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // transfer monitors
   always @(posedge clock) begin
      result_type r;
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_tick({req_command_button, req_reset_button, req_open_limit_hit,
                          req_closed_limit_hit, req_main_encoder_pulse, req_hall_pulses});
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (rsp_valid && rsp_ready) begin
            r.door_state = rsp_door_state;
            r.relay_open_on = rsp_relay_open_on;
            r.relay_close_on = rsp_relay_close_on;
            r.power_enable = rsp_power_enable;
            r.fire_delay_us = rsp_fire_delay_us;
            r.led_on = rsp_led_on;
            r.event_res = rsp_event_res;
            r.trip_complete = rsp_trip_complete;
            r.trip_count = rsp_trip_count;
            sb.check(r);
         end
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result receiver: random stalls, and one long hold-off on request
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            hold_req = 0;
         end
         n = $urandom_range(0, 99);
         if (n < 60) rsp_ready = 1'b1;
         else if (n < 70) begin
            rsp_ready = 1'b1;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end else if (n < 96) rsp_ready = 1'b0;
         else begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(20, 80)) @(negedge clock);
         end
         @(negedge clock);
      end
   end

   task automatic push_tick(tick_type t);
      int n, gap;
      n = $urandom_range(0, 99);
      gap = (n < 70) ? 0 : (n < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command_button = t.command_button;
      req_reset_button = t.reset_button;
      req_open_limit_hit = t.open_limit_hit;
      req_closed_limit_hit = t.closed_limit_hit;
      req_main_encoder_pulse = t.main_encoder_pulse;
      req_hall_pulses = t.hall_pulses;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // wait for every pending result, then let the block settle
   task automatic drain();
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_all(logic [15:0] v[8]);
      write_reg(CSR_RELAY, v[0]);
      write_reg(CSR_REVERSE, v[1]);
      write_reg(CSR_STALL, v[2]);
      write_reg(CSR_DOUBLE, v[3]);
      write_reg(CSR_DEBOUNCE, v[4]);
      write_reg(CSR_RAMP, v[5]);
      write_reg(CSR_FSTART, v[6]);
      write_reg(CSR_FCRUISE, v[7]);
   endtask

   task automatic tick(bit cmd, bit rst, bit ol, bit cl, bit enc, logic [3:0] hall);
      push_tick({cmd, rst, ol, cl, enc, hall});
   endtask

   // random ticks: button sequences with noisy limits and encoder activity
   task automatic random_ticks(int count, int enc_pct);
      tick_type t;
      bit cmd, rst;
      cmd = 0;
      rst = 0;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) cmd = !cmd;
         if ($urandom_range(0, 9) == 0) rst = !rst;
         t.command_button = cmd;
         t.reset_button = rst;
         t.open_limit_hit = ($urandom_range(0, 99) < 12);
         t.closed_limit_hit = ($urandom_range(0, 99) < 12);
         t.main_encoder_pulse = ($urandom_range(0, 99) < enc_pct);
         t.hall_pulses = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
         push_tick(t);
      end
   endtask

   initial begin
      logic [15:0] v[8];
      sb = new();
      hold_req = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command_button = 0; req_reset_button = 0; req_open_limit_hit = 0;
      req_closed_limit_hit = 0; req_main_encoder_pulse = 0; req_hall_pulses = 0;
      csr_valid = 1'b0; csr_index = CSR_RELAY; csr_data = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: short timings, trip from the open limit, stall, reset, double press
      v = '{16'd1, 16'd2, 16'd3, 16'd3, 16'd0, 16'd3, 16'd8000, 16'd1000};
      write_all(v);
      tick(0, 1, 0, 0, 0, 4'd0);           // reset outside error
      tick(1, 0, 1, 1, 1, 4'd15);          // both limits, press
      tick(0, 0, 0, 0, 1, 4'd15);
      tick(0, 0, 0, 0, 1, 4'd7);
      tick(0, 0, 0, 0, 1, 4'd0);
      tick(0, 0, 0, 1, 0, 4'd3);           // arrival at closed limit
      tick(1, 0, 0, 1, 1, 4'd0);           // start opening
      tick(0, 0, 0, 0, 0, 4'd0);
      tick(0, 0, 0, 0, 0, 4'd0);
      tick(0, 0, 0, 0, 0, 4'd0);
      tick(0, 0, 0, 0, 0, 4'd0);
      tick(0, 0, 0, 0, 0, 4'd0);
      tick(0, 0, 0, 0, 0, 4'd0);           // already in error after the stall
      tick(1, 0, 0, 0, 0, 4'd0);           // ignored in error
      tick(0, 1, 0, 0, 0, 4'd0);           // error reset
      tick(1, 0, 0, 0, 1, 4'd1);           // start
      tick(0, 0, 0, 0, 1, 4'd1);
      tick(1, 0, 0, 0, 1, 4'd1);           // stop, reversal pending
      tick(0, 0, 0, 0, 1, 4'd1);
      tick(1, 0, 0, 0, 1, 4'd1);           // double press cancels
      tick(0, 0, 0, 0, 1, 4'd0);
      drain();

      // random phases over several register settings
      for (int p = 0; p < 7; p++) begin
         case (p)
            0: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            1: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF};
            2: v = '{16'd2, 16'd4, 16'd6, 16'd5, 16'd1, 16'd20, 16'd500, 16'd9000};
            default: begin
               v[0] = 16'($urandom_range(0, 6));
               v[1] = 16'($urandom_range(0, 8));
               v[2] = 16'($urandom_range(0, 12));
               v[3] = 16'($urandom_range(0, 10));
               v[4] = 16'($urandom_range(0, 4));
               v[5] = 16'($urandom_range(0, 40));
               v[6] = 16'($urandom_range(0, 16'hFFFF));
               v[7] = 16'($urandom_range(0, 16'hFFFF));
            end
         endcase
         write_all(v);
         if (p == 3) hold_req = 1;
         random_ticks(200, (p == 4) ? 40 : 80);
         drain();
      end
      write_all('{16'd100, 16'd1000, 16'd1000, 16'd500, 16'd50, 16'd2000,
                  16'd8000, 16'd1000});
      random_ticks(60, 80);
      drain();

      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
